// ----- hdl/fsa_pkg.sv -----
// Shared constants, operation and status codes, and scanner result type for the slot allocator.
package fsa_pkg;

	// default table sizes
	localparam int unsigned DESCRIPTORS_DEF = 128;
	localparam int unsigned SLOTS_DEF       = 256;
	localparam int unsigned COUNT_BITS_DEF  = 8;

	// occupancy bitmap is scanned one word per cycle
	localparam int unsigned SCAN_W  = 16;
	localparam int unsigned SCAN_LW = $clog2(SCAN_W);

	// operation codes
	localparam logic [2:0] OP_ALLOC   = 3'd0;
	localparam logic [2:0] OP_LOOKUP  = 3'd1;
	localparam logic [2:0] OP_CLOSE   = 3'd2;
	localparam logic [2:0] OP_ADDREF  = 3'd3;
	localparam logic [2:0] OP_RELEASE = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_DESC  = 3'd1;
	localparam logic [2:0] ST_NO_SLOT  = 3'd2;
	localparam logic [2:0] ST_BAD_DESC = 3'd3;
	localparam logic [2:0] ST_SAT      = 3'd4;

	// scanner completion flags
	typedef struct packed {
		logic done;
		logic found;
	} scan_res_t;

endpackage

// ----- hdl/fsa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module fsa_ram
	import fsa_pkg::*;
#(
	parameter int unsigned WIDTH = COUNT_BITS_DEF,
	parameter int unsigned DEPTH = SLOTS_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/fsa_scan.sv -----
// Wrapping first-free search over an occupancy bitmap, one word per cycle.
module fsa_scan
	import fsa_pkg::*;
#(
	parameter int unsigned N = SLOTS_DEF,
	localparam int unsigned IW   = $clog2(N),
	localparam int unsigned NG   = (N + SCAN_W - 1) / SCAN_W,
	localparam int unsigned GW   = (NG > 1) ? $clog2(NG) : 1,
	localparam int unsigned SW   = $clog2(NG + 1),
	localparam int unsigned PADN = NG * SCAN_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [IW-1:0] start_idx,
	input  logic [N-1:0]  map,
	output scan_res_t     res,
	output logic [IW-1:0] idx
);

	logic                    busy_q;
	logic                    first_q;
	logic [GW-1:0]           grp_q;
	logic [SCAN_LW-1:0]      lo_q;
	logic [SW-1:0]           steps_q;
	logic [PADN-1:0]         map_pad;
	logic [GW+SCAN_LW-1:0]   start_ext;
	logic [SCAN_W-1:0]       word;
	logic [SCAN_W-1:0]       low_mask;
	logic [SCAN_W-1:0]       free;
	logic [SCAN_LW-1:0]      off;
	logic [GW+SCAN_LW-1:0]   idx_full;
	logic                    hit;
	logic                    last_step;

	// pad bits past the table read as occupied
	always_comb begin
		map_pad = '1;
		map_pad[N-1:0] = map;
	end

	assign start_ext = (GW + SCAN_LW)'(start_idx);

	// first word ignores entries below the start point; the start word is revisited last
	assign word      = map_pad[grp_q * SCAN_W +: SCAN_W];
	assign low_mask  = first_q ? ((SCAN_W'(1) << lo_q) - SCAN_W'(1)) : '0;
	assign free      = ~word & ~low_mask;
	assign hit       = |free;
	assign last_step = (steps_q == SW'(NG));

	// lowest free entry in the word
	always_comb begin
		off = '0;
		for (int i = SCAN_W - 1; i >= 0; i--) begin
			if (free[i]) begin
				off = SCAN_LW'(i);
			end
		end
	end

	assign idx_full  = {grp_q, off};
	assign idx       = idx_full[IW-1:0];
	assign res.done  = busy_q && (hit || last_step);
	assign res.found = busy_q && hit;

	// word pointer with wrap-around
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			grp_q   <= '0;
			lo_q    <= '0;
			steps_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			first_q <= 1'b1;
			grp_q   <= start_ext[GW+SCAN_LW-1:SCAN_LW];
			lo_q    <= start_ext[SCAN_LW-1:0];
			steps_q <= '0;
		end else if (busy_q) begin
			if (hit || last_step) begin
				busy_q <= 1'b0;
			end else begin
				grp_q   <= (grp_q == GW'(NG - 1)) ? '0 : grp_q + 1'b1;
				first_q <= 1'b0;
				steps_q <= steps_q + 1'b1;
			end
		end
	end

endmodule

// ----- hdl/file_slot_allocator_unit.sv -----
// Top level of the file slot allocator: descriptor table, reference-counted slot table, control.

// One request is handled at a time. Lookup, release, close, add reference and the unknown codes
// go through the sequencer without a search; allocate waits in the scan state for the two
// bitmap scanners, which walk the descriptor and slot occupancy maps 16 entries per cycle
// in parallel. Reference counts and descriptor bindings live in two RAMs with a registered
// read; a slot's busy bit doubles as the valid bit of its count entry, so no clearing pass
// is needed after reset. The result sits in an output register, so a new request is taken
// while the previous result waits to be taken.
module file_slot_allocator_unit
	import fsa_pkg::*;
#(
	parameter int unsigned DESCRIPTORS = DESCRIPTORS_DEF,
	parameter int unsigned SLOTS       = SLOTS_DEF,
	parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       request_valid,
	output logic       request_stall,
	input  logic [2:0] operation,
	input  logic [7:0] descriptor_in,
	input  logic [7:0] slot_in,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [2:0] status,
	output logic [6:0] descriptor_out,
	output logic [7:0] slot_out,
	output logic       last_reference
);

	localparam int unsigned DA_W = $clog2(DESCRIPTORS);
	localparam int unsigned SA_W = $clog2(SLOTS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_SCAN = 5'b00100,
		S_MOD  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [2:0]             op_q;
	logic [7:0]             d_q;
	logic [7:0]             s_q;
	logic [DESCRIPTORS-1:0] desc_used_q;
	logic [SLOTS-1:0]       slot_busy_q;
	logic [7:0]             search_q;
	logic                   dd_q, df_q, sd_q, sf_q;
	logic [DA_W-1:0]        di_q;
	logic [SA_W-1:0]        si_q;
	logic [2:0]             res_status_q;
	logic [6:0]             res_dout_q;
	logic [7:0]             res_sout_q;
	logic                   res_last_q;
	logic                   out_valid_q;

	logic                   accept;
	logic                   out_load;
	logic                   d_ok, d_bound, s_ok, s_busy;
	logic [DA_W-1:0]        d_addr;
	logic [SA_W-1:0]        s_addr;
	logic [SA_W-1:0]        start_eff;
	logic                   scan_go;
	logic                   commit, grant;
	scan_res_t              dscan_res, sscan_res;
	logic [DA_W-1:0]        dscan_idx;
	logic [SA_W-1:0]        sscan_idx;

	logic                   cnt_we;
	logic [SA_W-1:0]        cnt_waddr;
	logic [COUNT_BITS-1:0]  cnt_wdata;
	logic [COUNT_BITS-1:0]  cnt_rd;
	logic [7:0]             dsl_rd;
	logic                   rd_en;

	// handshake
	assign request_stall = (state_q != S_IDLE);
	assign accept        = request_valid && !request_stall;
	assign result_valid  = out_valid_q;
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || !result_stall);

	// range checks and bitmap lookups on the held request
	assign d_ok    = (9'(d_q) < 9'(DESCRIPTORS));
	assign s_ok    = (9'(s_q) < 9'(SLOTS));
	assign d_addr  = d_q[DA_W-1:0];
	assign s_addr  = s_q[SA_W-1:0];
	assign d_bound = d_ok && desc_used_q[d_addr];
	assign s_busy  = s_ok && slot_busy_q[s_addr];

	// next-fit start point; a pointer past the table restarts at slot zero
	assign start_eff = (9'(search_q) < 9'(SLOTS)) ? search_q[SA_W-1:0] : '0;
	assign scan_go   = (state_q == S_EXEC) && (op_q == OP_ALLOC);
	assign commit    = (state_q == S_SCAN) && dd_q && sd_q;
	assign grant     = commit && df_q && sf_q;
	assign rd_en     = (state_q == S_EXEC);

	fsa_scan #(.N(DESCRIPTORS)) u_dscan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_go),
		.start_idx ('0),
		.map       (desc_used_q),
		.res       (dscan_res),
		.idx       (dscan_idx)
	);

	fsa_scan #(.N(SLOTS)) u_sscan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_go),
		.start_idx (start_eff),
		.map       (slot_busy_q),
		.res       (sscan_res),
		.idx       (sscan_idx)
	);

	// reference counts; valid only where the slot busy bit is set
	fsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(SLOTS)) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (rd_en),
		.raddr (s_addr),
		.rdata (cnt_rd)
	);

	// descriptor to slot binding; read data used only for bound descriptors
	fsa_ram #(.WIDTH(8), .DEPTH(DESCRIPTORS)) u_bind_ram (
		.clk   (clk),
		.we    (grant),
		.waddr (di_q),
		.wdata (8'(si_q)),
		.re    (rd_en),
		.raddr (d_addr),
		.rdata (dsl_rd)
	);

	// count write-back: new slot, add reference, close
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = s_addr;
		cnt_wdata = COUNT_BITS'(1);
		case (state_q)
			S_EXEC: begin
				if (op_q == OP_ADDREF && s_ok && !s_busy) begin
					cnt_we = 1'b1;
				end
			end
			S_SCAN: begin
				if (grant) begin
					cnt_we    = 1'b1;
					cnt_waddr = si_q;
				end
			end
			S_MOD: begin
				if (op_q == OP_CLOSE && cnt_rd > COUNT_BITS'(1)) begin
					cnt_we    = 1'b1;
					cnt_wdata = cnt_rd - COUNT_BITS'(1);
				end else if (op_q == OP_ADDREF && cnt_rd != '1) begin
					cnt_we    = 1'b1;
					cnt_wdata = cnt_rd + COUNT_BITS'(1);
				end
			end
			default: ;
		endcase
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= '0;
			d_q          <= '0;
			s_q          <= '0;
			desc_used_q  <= '0;
			slot_busy_q  <= '0;
			search_q     <= '0;
			dd_q         <= 1'b0;
			df_q         <= 1'b0;
			di_q         <= '0;
			sd_q         <= 1'b0;
			sf_q         <= 1'b0;
			si_q         <= '0;
			res_status_q <= ST_OK;
			res_dout_q   <= '0;
			res_sout_q   <= '0;
			res_last_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= operation;
						d_q     <= descriptor_in;
						s_q     <= slot_in;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_dout_q <= '0;
					res_sout_q <= '0;
					res_last_q <= 1'b0;
					case (op_q)
						OP_ALLOC: begin
							res_status_q <= ST_OK;
							dd_q         <= 1'b0;
							sd_q         <= 1'b0;
							state_q      <= S_SCAN;
						end
						OP_LOOKUP: begin
							res_status_q <= d_bound ? ST_OK : ST_BAD_DESC;
							state_q      <= d_bound ? S_MOD : S_DONE;
						end
						OP_CLOSE: begin
							res_status_q <= ST_OK;
							state_q      <= s_busy ? S_MOD : S_DONE;
						end
						OP_ADDREF: begin
							res_status_q <= ST_OK;
							state_q      <= s_busy ? S_MOD : S_DONE;
							if (!s_busy && s_ok) begin
								slot_busy_q[s_addr] <= 1'b1;
							end
						end
						OP_RELEASE: begin
							res_status_q <= d_bound ? ST_OK : ST_BAD_DESC;
							state_q      <= S_DONE;
							if (d_bound) begin
								desc_used_q[d_addr] <= 1'b0;
							end
						end
						default: begin
							res_status_q <= ST_OK;
							state_q      <= S_DONE;
						end
					endcase
				end
				S_SCAN: begin
					if (dscan_res.done) begin
						dd_q <= 1'b1;
						df_q <= dscan_res.found;
						di_q <= dscan_idx;
					end
					if (sscan_res.done) begin
						sd_q <= 1'b1;
						sf_q <= sscan_res.found;
						si_q <= sscan_idx;
					end
					if (commit) begin
						state_q <= S_DONE;
						if (!df_q) begin
							res_status_q <= ST_NO_DESC;
						end else if (!sf_q) begin
							res_status_q <= ST_NO_SLOT;
						end else begin
							slot_busy_q[si_q] <= 1'b1;
							desc_used_q[di_q] <= 1'b1;
							search_q          <= 8'(si_q) + 8'd1;
							res_dout_q        <= 7'(di_q);
							res_sout_q        <= 8'(si_q);
						end
					end
				end
				S_MOD: begin
					state_q <= S_DONE;
					case (op_q)
						OP_LOOKUP: begin
							res_sout_q <= dsl_rd;
						end
						OP_CLOSE: begin
							if (!(cnt_rd > COUNT_BITS'(1))) begin
								slot_busy_q[s_addr] <= 1'b0;
								res_last_q          <= 1'b1;
							end
						end
						OP_ADDREF: begin
							if (cnt_rd == '1) begin
								res_status_q <= ST_SAT;
							end
						end
						default: ;
					endcase
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register; held while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			status         <= ST_OK;
			descriptor_out <= '0;
			slot_out       <= '0;
			last_reference <= 1'b0;
		end else if (out_load) begin
			status         <= res_status_q;
			descriptor_out <= res_dout_q;
			slot_out       <= res_sout_q;
			last_reference <= res_last_q;
			out_valid_q    <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// a granted slot and descriptor were both free
	assert property (@(posedge clk) disable iff (!arst_n)
		grant |-> (!slot_busy_q[si_q] && !desc_used_q[di_q]))
		else $error("allocate granted an occupied entry");

	// after a grant both entries are marked in use
	assert property (@(posedge clk) disable iff (!arst_n)
		grant |=> (slot_busy_q[si_q] && desc_used_q[di_q]))
		else $error("grant not recorded in bitmaps");

	// scanners only finish while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n)
		(dscan_res.done || sscan_res.done) |-> (state_q == S_SCAN))
		else $error("scanner finished outside a search");

	// a close only reads a count of an occupied slot
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD && op_q == OP_CLOSE) |-> slot_busy_q[s_addr])
		else $error("close modifying a free slot");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the file slot allocator: directed cases, table exhaustion, random traffic.
module tb_top
	import fsa_pkg::*;
();

	localparam int DESC_N      = DESCRIPTORS_DEF;
	localparam int SLOT_N      = SLOTS_DEF;
	localparam int COUNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_WAIT  = 40;

	// codes the block treats as no-ops
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] descriptor;
		logic [7:0] slot;
		logic       last_ref;
	} alloc_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       request_valid = 1'b0;
	logic       request_stall;
	logic [2:0] operation = 3'd0;
	logic [7:0] descriptor_in = 8'd0;
	logic [7:0] slot_in = 8'd0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [2:0] status;
	logic [6:0] descriptor_out;
	logic [7:0] slot_out;
	logic       last_reference;

	// shadow copy of the allocator tables
	logic                      desc_bound [DESC_N];
	logic [7:0]                desc_slot  [DESC_N];
	logic [COUNT_BITS_DEF-1:0] slot_count [SLOT_N];
	logic [7:0]                search_ptr;

	alloc_result_t pending_results[$];
	int            mismatch_count = 0;
	int            result_count = 0;
	int            cycle_count = 0;
	int            burst_left = 0;
	int            stall_left = 0;
	int            stall_mode = 0;

	file_slot_allocator_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.request_valid  (request_valid),
		.request_stall  (request_stall),
		.operation      (operation),
		.descriptor_in  (descriptor_in),
		.slot_in        (slot_in),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.status         (status),
		.descriptor_out (descriptor_out),
		.slot_out       (slot_out),
		.last_reference (last_reference)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver stall pattern: modes from never stalling to mostly stalled
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 64);
		end
		stall_left--;
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= $urandom_range(0, 1);
			default: result_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom);
	endfunction

	// expected outcome of one request; updates the shadow tables
	function automatic alloc_result_t predict_request(logic [2:0] op, logic [7:0] d,
			logic [7:0] s);
		alloc_result_t r;
		int fd, fs, start, idx;
		r = '0;
		fd = -1;
		fs = -1;
		case (op)
			OP_ALLOC: begin
				for (int i = 0; i < DESC_N; i++) begin
					if (!desc_bound[i] && fd < 0) fd = i;
				end
				if (fd < 0) begin
					r.status = ST_NO_DESC;
				end else begin
					// next fit from the rotating pointer, one wrap
					start = (int'(search_ptr) >= SLOT_N) ? 0 : int'(search_ptr);
					for (int i = 0; i < SLOT_N; i++) begin
						idx = (start + i) % SLOT_N;
						if (slot_count[idx] == 0 && fs < 0) fs = idx;
					end
					if (fs < 0) begin
						r.status = ST_NO_SLOT;
					end else begin
						slot_count[fs] = 1;
						search_ptr = 8'(fs + 1);
						desc_bound[fd] = 1'b1;
						desc_slot[fd] = 8'(fs);
						r.descriptor = 7'(fd);
						r.slot = 8'(fs);
					end
				end
			end
			OP_LOOKUP: begin
				if (int'(d) < DESC_N && desc_bound[d]) r.slot = desc_slot[d];
				else r.status = ST_BAD_DESC;
			end
			OP_CLOSE: begin
				if (int'(s) < SLOT_N) begin
					if (slot_count[s] > 1) begin
						slot_count[s] = slot_count[s] - 1'b1;
					end else if (slot_count[s] == 1) begin
						slot_count[s] = '0;
						r.last_ref = 1'b1;
					end
				end
			end
			OP_ADDREF: begin
				if (int'(s) < SLOT_N) begin
					if (int'(slot_count[s]) >= COUNT_MAX) r.status = ST_SAT;
					else slot_count[s] = slot_count[s] + 1'b1;
				end
			end
			OP_RELEASE: begin
				if (int'(d) < DESC_N && desc_bound[d]) desc_bound[d] = 1'b0;
				else r.status = ST_BAD_DESC;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int free_descriptors();
		int n;
		n = 0;
		for (int i = 0; i < DESC_N; i++) if (!desc_bound[i]) n++;
		return n;
	endfunction

	function automatic int free_slots();
		int n;
		n = 0;
		for (int i = 0; i < SLOT_N; i++) if (slot_count[i] == 0) n++;
		return n;
	endfunction

	// random free slot, or -1 when the slot table is full
	function automatic int pick_free_slot();
		int base, idx;
		base = $urandom_range(0, SLOT_N - 1);
		for (int i = 0; i < SLOT_N; i++) begin
			idx = (base + i) % SLOT_N;
			if (slot_count[idx] == 0) return idx;
		end
		return -1;
	endfunction

	// random bound descriptor, or -1 when none is bound
	function automatic int pick_bound_descriptor();
		int base, idx;
		base = $urandom_range(0, DESC_N - 1);
		for (int i = 0; i < DESC_N; i++) begin
			idx = (base + i) % DESC_N;
			if (desc_bound[idx]) return idx;
		end
		return -1;
	endfunction

	// send one request: bursts with random gaps, payload held while stalled
	task automatic send_request(logic [2:0] op, logic [7:0] d, logic [7:0] s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				request_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		request_valid <= 1'b1;
		operation <= op;
		descriptor_in <= d;
		slot_in <= s;
		do @(posedge clk); while (request_stall !== 1'b0);
		pending_results.push_back(predict_request(op, d, s));
	endtask

	// hold off until every outstanding result has come back
	task automatic wait_all_results();
		@(negedge clk);
		request_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic note_error(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("%s", msg);
	endtask

	// result checker
	always @(posedge clk) begin
		alloc_result_t got, want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			got = {status, descriptor_out, slot_out, last_reference};
			if (pending_results.size() == 0) begin
				note_error($sformatf("result %0d: unexpected, status %0d desc %0d slot %0d last %0b",
					result_count, got.status, got.descriptor, got.slot, got.last_ref));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.descriptor !== want.descriptor ||
						got.slot !== want.slot || got.last_ref !== want.last_ref)
					note_error($sformatf({"result %0d: expected status %0d desc %0d slot %0d ",
						"last %0b, got status %0d desc %0d slot %0d last %0b"}, result_count,
						want.status, want.descriptor, want.slot, want.last_ref,
						got.status, got.descriptor, got.slot, got.last_ref));
			end
			result_count++;
		end
	end

	task automatic test_directed_cases();
		// empty tables: nothing bound, descriptor beyond the table
		send_request(OP_LOOKUP, 8'd0, 8'd0);
		send_request(OP_RELEASE, 8'd0, 8'hFF);
		send_request(OP_LOOKUP, 8'hFF, 8'h00);
		send_request(OP_RELEASE, 8'd128, 8'd0);
		// close of a free slot changes nothing
		send_request(OP_CLOSE, 8'h00, 8'd5);
		send_request(OP_ALLOC, 8'hFF, 8'hFF);
		send_request(OP_ALLOC, 8'h00, 8'h00);
		send_request(OP_LOOKUP, 8'd0, 8'hFF);
		send_request(OP_LOOKUP, 8'd127, 8'd0);
		// add reference to free slots: in use with no descriptor, skipped by next fit
		send_request(OP_ADDREF, 8'h00, 8'hFF);
		send_request(OP_ADDREF, 8'hFF, 8'd2);
		send_request(OP_ALLOC, 8'h5A, 8'hA5);
		// last close of a bound slot; the binding stays until release
		send_request(OP_CLOSE, 8'h00, 8'd1);
		send_request(OP_LOOKUP, 8'd1, 8'd0);
		send_request(OP_RELEASE, 8'd1, 8'd0);
		send_request(OP_RELEASE, 8'd1, 8'd0);
		send_request(OP_ALLOC, 8'h00, 8'h00);
		// shared slot: count 2, then down to free
		send_request(OP_ADDREF, 8'h00, 8'd0);
		send_request(OP_CLOSE, 8'h00, 8'd0);
		send_request(OP_CLOSE, 8'h00, 8'd0);
		send_request(OP_RSVD5, 8'hFF, 8'hFF);
		send_request(OP_RSVD6, 8'h00, 8'h00);
		send_request(OP_RSVD7, 8'hAA, 8'h55);
	endtask

	// push one slot's count to the top and past it
	task automatic test_count_saturation();
		int target;
		target = $urandom_range(0, SLOT_N - 1);
		while (int'(slot_count[target]) != COUNT_MAX)
			send_request(OP_ADDREF, rand_byte(), 8'(target));
		repeat (2) send_request(OP_ADDREF, rand_byte(), 8'(target));
		repeat (3) send_request(OP_CLOSE, rand_byte(), 8'(target));
	endtask

	// fill the descriptor table, then the slot table
	task automatic test_table_exhaustion();
		int d;
		while (free_descriptors() > 0 && free_slots() > 0) begin
			if ($urandom_range(0, 7) != 0)
				send_request(OP_ALLOC, rand_byte(), rand_byte());
			else
				send_request(OP_LOOKUP, 8'($urandom_range(0, DESC_N - 1)), rand_byte());
		end
		send_request(OP_ALLOC, rand_byte(), rand_byte());
		while (free_slots() > 0) begin
			if ($urandom_range(0, 7) != 0)
				send_request(OP_ADDREF, rand_byte(), 8'(pick_free_slot()));
			else
				send_request(OP_ALLOC, rand_byte(), rand_byte());
		end
		send_request(OP_ALLOC, rand_byte(), rand_byte());
		// a free descriptor but no free slot: descriptor must stay free
		d = pick_bound_descriptor();
		send_request(OP_RELEASE, 8'(d), rand_byte());
		send_request(OP_ALLOC, rand_byte(), rand_byte());
		send_request(OP_LOOKUP, 8'(d), rand_byte());
		send_request(OP_ALLOC, rand_byte(), rand_byte());
	endtask

	// mixed traffic, mostly on live descriptors
	task automatic test_random_traffic(int count);
		int pick, d;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			d = pick_bound_descriptor();
			if (d < 0 || $urandom_range(0, 4) == 0) d = $urandom_range(0, 255);
			if (pick < 30)
				send_request(OP_CLOSE, rand_byte(), rand_byte());
			else if (pick < 55)
				send_request(OP_ALLOC, rand_byte(), rand_byte());
			else if (pick < 70)
				send_request(OP_RELEASE, 8'(d), rand_byte());
			else if (pick < 85)
				send_request(OP_LOOKUP, 8'(d), rand_byte());
			else if (pick < 95)
				send_request(OP_ADDREF, rand_byte(), rand_byte());
			else
				send_request(3'($urandom_range(OP_RSVD5, OP_RSVD7)), rand_byte(), rand_byte());
		end
	endtask

	initial begin
		for (int i = 0; i < DESC_N; i++) begin
			desc_bound[i] = 1'b0;
			desc_slot[i] = '0;
		end
		for (int i = 0; i < SLOT_N; i++) slot_count[i] = '0;
		search_ptr = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		wait_all_results();
		test_count_saturation();
		test_table_exhaustion();
		wait_all_results();
		test_random_traffic(40);

		wait_all_results();
		repeat (DRAIN_WAIT) @(posedge clk);
		mismatch_count += pending_results.size();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
